// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the front panel controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("front panel assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("front panel assertion failed");

`endif

// ===== hdl/rfpc_pkg.sv =====
// Package with key codes, source codes and the source switch table.
package rfpc_pkg;

  localparam int DEBOUNCE_BITS  = 16;
  localparam int CFG_INDEX_BITS = 1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DEBOUNCE_TICKS   = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_POWER_ACTIVE_LOW = 1'd1;

  localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = 16'd50;

  // Front panel key codes.
  localparam logic [3:0] KEY_UNKNOWN    = 4'd0;
  localparam logic [3:0] KEY_VIDEO      = 4'd1;
  localparam logic [3:0] KEY_PHONO      = 4'd7;
  localparam logic [3:0] KEY_BASS_BOOST = 4'd8;
  localparam logic [3:0] KEY_MUTE       = 4'd9;

  // Source codes.
  localparam logic [2:0] VIDEO        = 3'd0;
  localparam logic [2:0] TV_LD        = 3'd1;
  localparam logic [2:0] MD_TAPE      = 3'd2;
  localparam logic [2:0] SURROUND_DVD = 3'd3;
  localparam logic [2:0] CD_SRC       = 3'd4;
  localparam logic [2:0] TUNER        = 3'd5;
  localparam logic [2:0] PHONO        = 3'd6;

  // Source switch codes.
  localparam logic [2:0] SW_ALL_OFF = 3'd0;
  localparam logic [2:0] SW_PHONO   = 3'd1;
  localparam logic [2:0] SW_CD      = 3'd2;
  localparam logic [2:0] SW_TUNER   = 3'd3;
  localparam logic [2:0] SW_VIDEO   = 3'd4;
  localparam logic [2:0] SW_TV_LD   = 3'd5;
  localparam logic [2:0] SW_MD_TAPE = 3'd6;

  function automatic logic [2:0] switch_of_source(input logic [2:0] src);
    logic [2:0] code;
    case (src)
      VIDEO:   code = SW_VIDEO;
      TV_LD:   code = SW_TV_LD;
      MD_TAPE: code = SW_MD_TAPE;
      CD_SRC:  code = SW_CD;
      TUNER:   code = SW_TUNER;
      PHONO:   code = SW_PHONO;
      default: code = SW_ALL_OFF;
    endcase
    return code;
  endfunction

endpackage

// ===== hdl/receiver_front_panel_controller_unit.sv =====
// An accepted item is held in the input register, and its result then in the result register.
// Throughput: one item per cycle when the output is not stalled; input and result registers hold one item each.
// The loop that sets the rate is the state update (debounce count, power, source, bass, mute).
// Reset (rst, synchronous, active high) empties both registers, returns to standby on video,
// sets debounce_ticks to 50 and power_active_low to 1.
`include "assert_macros.svh"

module receiver_front_panel_controller_unit
  import rfpc_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [DEBOUNCE_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      power_pin,
  input  logic                      panel_pressed,
  input  logic [3:0]                panel_key,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      powered_on,
  output logic [2:0]                source_now,
  output logic [2:0]                switch_code,
  output logic                      five_one_led_level,
  output logic                      bass_led_level,
  output logic                      mute_led_level
);

  localparam int CMP_BITS = (COUNT_BITS > DEBOUNCE_BITS) ? COUNT_BITS : DEBOUNCE_BITS;

  // Configuration.
  logic [DEBOUNCE_BITS-1:0] debounce_ticks;
  logic                     power_active_low;

  // Input register.
  logic       s1_valid;
  logic       s1_power_pin;
  logic       s1_panel_pressed;
  logic [3:0] s1_panel_key;

  // Controller state.
  logic                  power_raw_seen, power_raw_seen_next;
  logic                  power_stable, power_stable_next;
  logic [COUNT_BITS-1:0] ticks_since_change, ticks_since_change_next;
  logic                  power_state, power_state_next;
  logic [2:0]            source_sel, source_sel_next;
  logic                  bass_on, bass_on_next;
  logic                  mute_on, mute_on_next;
  logic                  panel_last;

  logic raw;
  logic advance;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= DEBOUNCE_RESET;
      power_active_low <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DEBOUNCE_TICKS:   debounce_ticks   <= cfg_data;
        CFG_POWER_ACTIVE_LOW: power_active_low <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_power_pin     <= power_pin;
      s1_panel_pressed <= panel_pressed;
      s1_panel_key     <= panel_key;
    end
  end

  always_comb begin
    raw                     = power_active_low ? !s1_power_pin : s1_power_pin;
    power_raw_seen_next     = power_raw_seen;
    ticks_since_change_next = ticks_since_change;
    power_stable_next       = power_stable;
    power_state_next        = power_state;
    source_sel_next         = source_sel;
    bass_on_next            = bass_on;
    mute_on_next            = mute_on;

    if (raw != power_raw_seen) begin
      power_raw_seen_next     = raw;
      ticks_since_change_next = '0;
    end else if (ticks_since_change != {COUNT_BITS{1'b1}}) begin
      ticks_since_change_next = ticks_since_change + 1'b1;
    end

    if (raw != power_stable &&
        CMP_BITS'(ticks_since_change_next) >= CMP_BITS'(debounce_ticks)) begin
      power_stable_next = raw;
      if (raw) begin
        power_state_next = !power_state;
      end
    end

    // A new panel press acts only with the power state of this same item.
    if (s1_panel_pressed && !panel_last && power_state_next) begin
      case (s1_panel_key) inside
        [KEY_VIDEO:KEY_PHONO]: source_sel_next = 3'(s1_panel_key - KEY_VIDEO);
        KEY_BASS_BOOST:        bass_on_next    = !bass_on;
        KEY_MUTE:              mute_on_next    = !mute_on;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_raw_seen     <= 1'b0;
      power_stable       <= 1'b0;
      ticks_since_change <= '0;
      power_state        <= 1'b0;
      source_sel         <= VIDEO;
      bass_on            <= 1'b0;
      mute_on            <= 1'b0;
      panel_last         <= 1'b0;
    end else if (advance) begin
      power_raw_seen     <= power_raw_seen_next;
      power_stable       <= power_stable_next;
      ticks_since_change <= ticks_since_change_next;
      power_state        <= power_state_next;
      source_sel         <= source_sel_next;
      bass_on            <= bass_on_next;
      mute_on            <= mute_on_next;
      panel_last         <= s1_panel_pressed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      powered_on         <= power_state_next;
      source_now         <= source_sel_next;
      switch_code        <= power_state_next ? switch_of_source(source_sel_next) : SW_ALL_OFF;
      five_one_led_level <= !(power_state_next && source_sel_next == SURROUND_DVD);
      bass_led_level     <= power_state_next && bass_on_next;
      mute_led_level     <= !(power_state_next && mute_on_next);
    end
  end

  `ASSERT_SAME(a_standby_outputs_off, clk, rst, out_valid && !powered_on,
    switch_code == SW_ALL_OFF && five_one_led_level && !bass_led_level && mute_led_level)
  `ASSERT_SAME(a_power_needs_press, clk, rst, power_state != $past(power_state),
    power_stable && !$past(power_stable))
  `ASSERT_SAME(a_source_only_when_on, clk, rst, source_sel != $past(source_sel),
    power_state)
  `ASSERT_SAME(a_ready_when_unstalled, clk, rst, !out_valid || out_ready, in_ready)
  `ASSERT_NEXT(a_item_reaches_output, clk, rst, advance, out_valid)

endmodule
